/* rtl/stream_word_replace_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the streaming find-and-replace block
// Shared property forms, sampled on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_WORD_REPLACE_ASSERT_SVH
`define STREAM_WORD_REPLACE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swr_pkg.sv */
// ----------------------------------------------------------------------------
// swr_pkg
// Types and constants shared by the find-and-replace front end, queue and
// output sequencer.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int BYTE_W     = 8;
  localparam int JOB_BYTES  = 8;
  localparam int JOB_W      = JOB_BYTES * BYTE_W;
  localparam int JCNT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN  = 2'd0,
    CFG_PAT_DATA = 2'd1,
    CFG_REP_LEN  = 2'd2,
    CFG_REP_DATA = 2'd3
  } cfg_idx_t;

  // One unit of output work: cnt bytes taken from data, lowest byte first.
  // A job with cnt zero is a bare end-of-stream marker.
  typedef struct packed {
    logic [JOB_W-1:0]  data;
    logic [JCNT_W-1:0] cnt;
    logic              eos;
  } job_t;

  // Queue status seen by the front end and the sequencer.
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

/* rtl/stream_word_replace.sv */
// ----------------------------------------------------------------------------
// stream_word_replace
// Streaming find-and-replace on a byte stream: every leftmost, non-overlapping
// occurrence of a configured pattern is replaced by a configured replacement.
//
//   Channel  Direction  Payload
//   in_      sink       tdata = byte; tlast = last byte of the stream
//   out_     source     tdata = byte; tlast = last result of its input;
//                       tuser = {stream end, byte valid}
//   cfg_     sink       write enable, register index, 64-bit write data
//
// One input byte is accepted per cycle while the two-entry job queue has room.
// The sequencer emits one result per cycle unless the output stalls; results
// pass the job queue, the job register and the registered output stage.
// Reset is synchronous and leaves the window empty.
// Either side may stall without losing or repeating a transaction.
// ----------------------------------------------------------------------------
module stream_word_replace
  import swr_pkg::*;
#(
  parameter int MAX_WORD = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] out_byte
  output logic                  out_tlast,
  output logic [1:0]            out_tuser   // [0] byte_valid, [1] stream_end
);

  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, head_job;

  // Front end: configuration, window and match decision.
  swr_front #(
    .MAX_WORD (MAX_WORD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue.
  swr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_stat   (q_stat),
    .head_job (head_job)
  );

  // Output sequencer.
  swr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/swr_front.sv */
// ----------------------------------------------------------------------------
// swr_front
// Holds the configuration and the match window, accepts input bytes and turns
// each transaction into at most one output job for the queue.
// ----------------------------------------------------------------------------
module swr_front
  import swr_pkg::*;
#(
  parameter int MAX_WORD = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,
  input  logic                  in_tlast,
  input  q_stat_t               q_stat,
  output logic                  push,
  output job_t                  push_job
);

  localparam int CW = $clog2(MAX_WORD + 1);

  logic [JCNT_W-1:0]                 plen_r, plen_nxt;
  logic [CFG_DATA_W-1:0]             pat_r, pat_nxt;
  logic [JCNT_W-1:0]                 rlen_r, rlen_nxt;
  logic [CFG_DATA_W-1:0]             rep_r, rep_nxt;
  logic [MAX_WORD-1:0][BYTE_W-1:0]   win_r, win_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;

  logic                              accept;
  logic [CW-1:0]                     plen_eff;
  logic [JCNT_W-1:0]                 rlen_eff;
  logic [CW-1:0]                     c0, c1, k;
  logic [MAX_WORD-1:0][BYTE_W-1:0]   w, w_sh;
  logic                              mismatch, match;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Configuration writes.
  always_comb begin
    plen_nxt = plen_r;
    pat_nxt  = pat_r;
    rlen_nxt = rlen_r;
    rep_nxt  = rep_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAT_LEN:  plen_nxt = cfg_data[JCNT_W-1:0];
        CFG_PAT_DATA: pat_nxt  = cfg_data;
        CFG_REP_LEN:  rlen_nxt = cfg_data[JCNT_W-1:0];
        CFG_REP_DATA: rep_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective lengths: pattern clamped to one up to the window depth,
  // replacement clamped to eight bytes.
  always_comb begin
    if (plen_r == '0) begin
      plen_eff = CW'(1);
    end else if (32'(plen_r) > MAX_WORD) begin
      plen_eff = CW'(MAX_WORD);
    end else begin
      plen_eff = plen_r[CW-1:0];
    end
    if (32'(rlen_r) > JOB_BYTES) begin
      rlen_eff = JCNT_W'(JOB_BYTES);
    end else begin
      rlen_eff = rlen_r;
    end
  end

  // Window with the new byte appended, and the pattern compare.
  always_comb begin
    c0 = (cnt_r >= CW'(MAX_WORD)) ? CW'(MAX_WORD - 1) : cnt_r;
    c1 = c0 + CW'(1);
    mismatch = 1'b0;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (CW'(i) < c0) begin
        w[i] = win_r[i];
      end else if (CW'(i) == c0) begin
        w[i] = in_tdata;
      end else begin
        w[i] = '0;
      end
      if (CW'(i) < plen_eff && w[i] != pat_r[BYTE_W*i +: BYTE_W]) begin
        mismatch = 1'b1;
      end
    end
    match = (c1 == plen_eff) && !mismatch;
    // Bytes pushed out at the front when the window overflows or misses.
    k     = (c1 >= plen_eff) ? (c1 - plen_eff + CW'(1)) : '0;
    w_sh  = w >> {k, 3'b000};
  end

  // Job building and window update.
  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (match) begin
      push_job.data = rep_r;
      push_job.cnt  = rlen_eff;
    end else begin
      push_job.data = JOB_W'(w);
      push_job.cnt  = in_tlast ? JCNT_W'(c1) : JCNT_W'(k);
    end
    push_job.eos = in_tlast;
    push = accept && ((push_job.cnt != '0) || in_tlast);
    if (accept) begin
      if (match || in_tlast) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = c1 - k;
        win_nxt = w_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= JCNT_W'(1);
      pat_r  <= '0;
      rlen_r <= '0;
      rep_r  <= '0;
      cnt_r  <= '0;
    end else begin
      plen_r <= plen_nxt;
      pat_r  <= pat_nxt;
      rlen_r <= rlen_nxt;
      rep_r  <= rep_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Window bytes are only read below the fill count.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

/* rtl/swr_queue.sv */
// ----------------------------------------------------------------------------
// swr_queue
// Short job queue between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module swr_queue
  import swr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output q_stat_t q_stat,
  output job_t    head_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign q_stat.valid = (fill_r != '0);
  assign q_stat.full  = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign head_job     = mem[rd_ptr_r];

  // Pointer and fill bookkeeping; both ends wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/swr_back.sv */
// ----------------------------------------------------------------------------
// swr_back
// Output sequencer: takes jobs from the queue and plays them out one byte a
// cycle, unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module swr_back
  import swr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  job_t              head_job,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  logic              busy_r, busy_nxt;
  logic [JOB_W-1:0]  sh_r, sh_nxt;
  logic [JCNT_W-1:0] rem_r, rem_nxt;
  logic              eos_r, eos_nxt;

  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              olast_r, olast_nxt;
  logic [1:0]        ouser_r, ouser_nxt;

  logic              load_out, cur_last, step, done;

  assign load_out = !ov_r || out_tready;
  assign cur_last = (rem_r <= JCNT_W'(1));
  assign step     = busy_r && load_out;
  assign done     = step && cur_last;
  assign pop      = q_stat.valid && (!busy_r || done);

  // Job register: load from the queue, then shift one byte out per step.
  always_comb begin
    busy_nxt = busy_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    eos_nxt  = eos_r;
    if (pop) begin
      busy_nxt = 1'b1;
      sh_nxt   = head_job.data;
      rem_nxt  = head_job.cnt;
      eos_nxt  = head_job.eos;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      sh_nxt  = sh_r >> BYTE_W;
      rem_nxt = rem_r - JCNT_W'(1);
    end
  end

  // Output stage. A job with no bytes left gives the bare end marker.
  always_comb begin
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    olast_nxt = olast_r;
    ouser_nxt = ouser_r;
    if (load_out) begin
      ov_nxt       = busy_r;
      ob_nxt       = (rem_r == '0) ? '0 : sh_r[BYTE_W-1:0];
      olast_nxt    = cur_last;
      ouser_nxt[0] = (rem_r != '0);
      ouser_nxt[1] = cur_last && eos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    rem_r   <= rem_nxt;
    eos_r   <= eos_nxt;
    ob_r    <= ob_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

endmodule

/* rtl/swr_checker.sv */
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks on the result channel of the find-and-replace block.
// ----------------------------------------------------------------------------
`include "stream_word_replace_assert.svh"

module swr_checker
  import swr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic [1:0]        out_tuser
);

  // A stalled transaction keeps its payload.
  `SWR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result changed while stalled")

  // A result without data is only the bare end marker.
  `SWR_ASSERT_SAME(a_bare_marker, out_tvalid && !out_tuser[0], out_tlast && out_tuser[1] && (out_tdata == '0), "malformed bare end marker")

  // The stream end always closes the run of its input.
  `SWR_ASSERT_SAME(a_end_is_last, out_tvalid && out_tuser[1], out_tlast, "stream end without run end")

  // Nothing is offered in the first cycle after reset.
  `SWR_ASSERT_SAME(a_reset_idle, $rose(rst_n), !out_tvalid, "result offered straight after reset")

endmodule

bind stream_word_replace swr_checker u_swr_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for stream_word_replace
// A table of directed transactions runs first. It covers the state after
// reset, patterns and replacements at their extreme lengths, saturated and
// zero lengths, a replacement that deletes matches, and a pattern length
// that is lowered in the middle of a stream. Randomised phases follow, each
// with its own pattern. They mostly send whole or partial pattern copies,
// with random bytes mixed in. Every output transaction is compared against
// a behavioural prediction of the rewritten stream or a value from the script.
// ----------------------------------------------------------------------------
module testbench;
  import swr_pkg::*;

  localparam int WORD_MAX    = 8;
  localparam int SETTLE      = 6;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 44;

  // One output transaction of the rewritten stream.
  typedef struct packed {
    logic [7:0] value;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;
  } result_t;

  typedef enum logic {DO_WRITE, DO_BYTE} step_kind_t;
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} check_t;

  typedef struct packed {
    step_kind_t  kind;
    cfg_idx_t    reg_sel;
    logic [63:0] wdata;
    logic [7:0]  data;
    logic        last;
    check_t      check;
    result_t     want;
  } step_t;

  // Directed script. The registers start at pattern length 1, pattern 0 and
  // an empty replacement, so a zero byte is deleted straight after reset.
  localparam step_t SCRIPT [35] = '{
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h00, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b1, ONE_RESULT, '{8'hFF, 1'b1, 1'b1, 1'b1}},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h00, 1'b1, ONE_RESULT, '{8'h00, 1'b0, 1'b1, 1'b1}},
    // A zero pattern length acts as one; an oversized replacement saturates.
    '{DO_WRITE, CFG_PAT_LEN,  64'h0, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_WRITE, CFG_PAT_DATA, 64'h41, 8'h00, 1'b0, BY_MODEL,  '0},
    '{DO_WRITE, CFG_REP_LEN,  64'hF, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_WRITE, CFG_REP_DATA, 64'h8877665544332211, 8'h00, 1'b0, BY_MODEL, '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h41, 1'b0, BY_MODEL,   '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h42, 1'b1, ONE_RESULT, '{8'h42, 1'b1, 1'b1, 1'b1}},
    // An oversized pattern length saturates to the full window.
    '{DO_WRITE, CFG_PAT_LEN,  64'hF, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_WRITE, CFG_PAT_DATA, 64'hFFFFFFFFFFFFFFFF, 8'h00, 1'b0, BY_MODEL, '0},
    '{DO_WRITE, CFG_REP_LEN,  64'h0, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'hFF, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h00, 1'b1, ONE_RESULT, '{8'h00, 1'b1, 1'b1, 1'b1}},
    // Four-byte pattern, then the length is cut to two with three bytes held.
    '{DO_WRITE, CFG_PAT_LEN,  64'h4, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_WRITE, CFG_PAT_DATA, 64'h64636261, 8'h00, 1'b0, BY_MODEL, '0},
    '{DO_WRITE, CFG_REP_LEN,  64'h2, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_WRITE, CFG_REP_DATA, 64'h5A59, 8'h00, 1'b0, BY_MODEL, '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h61, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h62, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h63, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h64, 1'b0, BY_MODEL,   '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h61, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h62, 1'b0, NO_RESULT,  '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h63, 1'b0, NO_RESULT,  '0},
    '{DO_WRITE, CFG_PAT_LEN,  64'h2, 8'h00, 1'b0, BY_MODEL,   '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h78, 1'b0, BY_MODEL,   '0},
    '{DO_BYTE,  CFG_PAT_LEN,  64'h0, 8'h71, 1'b1, BY_MODEL,   '0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  cfg_idx_t    cfg_index  = CFG_PAT_LEN;
  logic [63:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;  // [7:0] in_byte
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] out_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;        // [0] byte_valid, [1] stream_end

  // Predicted register copies and matching window, at their reset values.
  logic [3:0]  pat_len     = 4'd1;
  logic [63:0] pattern     = '0;
  logic [3:0]  rep_len     = 4'd0;
  logic [63:0] replacement = '0;
  logic [7:0]  window [$];

  result_t step_results [$];
  result_t due_results [$];
  int      mismatches = 0;
  int      seen       = 0;
  int      hold_left  = 0;
  bit      held       = 1'b0;
  bit      no_idle    = 1'b0;
  int      quiet      = 0;
  result_t got;
  result_t want;

  stream_word_replace #(.MAX_WORD(WORD_MAX)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  task automatic note_mismatch(input string what, input int got_v, input int want_v);
    if (mismatches < 50) begin
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got_v, want_v);
    end
    mismatches++;
  endtask

  // Works out the results of one accepted byte into step_results.
  function automatic void rewrite_byte(input logic [7:0] b, input logic e);
    logic [7:0] emitted [$];
    int      plen;
    int      rlen;
    int      k;
    bit      hit;
    result_t r;
    plen = (pat_len == 0) ? 1 : ((pat_len > WORD_MAX) ? WORD_MAX : int'(pat_len));
    rlen = (rep_len > 8) ? 8 : int'(rep_len);
    while (window.size() >= WORD_MAX) void'(window.pop_back());
    window.push_back(b);
    if (window.size() > plen) begin
      // The window outgrew a lowered pattern length: drain without a compare.
      k = window.size() - plen + 1;
      for (int i = 0; i < k; i++) emitted.push_back(window.pop_front());
    end else if (window.size() == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (window[i] != pattern[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) emitted.push_back(replacement[8*i +: 8]);
        window.delete();
      end else begin
        emitted.push_back(window.pop_front());
      end
    end
    // End of stream flushes whatever is still held.
    if (e) begin
      while (window.size() != 0) emitted.push_back(window.pop_front());
    end
    while (emitted.size() > 8) void'(emitted.pop_back());
    step_results.delete();
    if (emitted.size() == 0) begin
      if (e) begin
        r = '{8'h00, 1'b0, 1'b1, 1'b1};
        step_results.push_back(r);
      end
    end else begin
      foreach (emitted[i]) begin
        r.value      = emitted[i];
        r.has_byte   = 1'b1;
        r.run_last   = (i == emitted.size() - 1);
        r.stream_end = (i == emitted.size() - 1) && e;
        step_results.push_back(r);
      end
    end
  endfunction

  // Offers one byte, with random idle cycles ahead of it unless no_idle is set, and
  // records what the accepted transaction should produce.
  task automatic send_byte(input logic [7:0] b, input logic e, input check_t how,
                           input result_t typed);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rewrite_byte(b, e);
    case (how)
      BY_MODEL:   foreach (step_results[i]) due_results.push_back(step_results[i]);
      ONE_RESULT: due_results.push_back(typed);
      default:    ;
    endcase
  endtask

  // Stops offering and waits until every result is in and the block is quiet.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PAT_LEN:  pat_len     = value[3:0];
      CFG_PAT_DATA: pattern     = value;
      CFG_REP_LEN:  rep_len     = value[3:0];
      CFG_REP_DATA: replacement = value;
      default:      ;
    endcase
  endtask

  // Result side: compare each transaction, and stall at random, with one
  // long hold-off, started while bytes are on offer, so that the job queue
  // fills and the input backs up.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen++;
      got = '{out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing pending", got, 0);
      end else begin
        want = due_results.pop_front();
        if (got.value != want.value) note_mismatch("out_byte", got.value, want.value);
        if (got.has_byte != want.has_byte) begin
          note_mismatch("byte_valid", got.has_byte, want.has_byte);
        end
        if (got.run_last != want.run_last) begin
          note_mismatch("run_last", got.run_last, want.run_last);
        end
        if (got.stream_end != want.stream_end) begin
          note_mismatch("stream_end", got.stream_end, want.stream_end);
        end
      end
    end
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (seen >= 100 && !held && in_tvalid) begin
      held       <= 1'b1;
      hold_left  <= 90;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog on cycles without any transaction or register write.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus: directed script, then randomised phases.
  initial begin
    logic [7:0]  alphabet [4];
    logic [7:0]  burst [$];
    logic [63:0] upper;
    int          plen_raw;
    int          rlen_raw;
    int          eff;
    int          sent;
    int          pick;
    int          cut;
    logic        last;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[s]) begin
      if (SCRIPT[s].kind == DO_WRITE) begin
        write_reg(SCRIPT[s].reg_sel, SCRIPT[s].wdata);
      end else begin
        send_byte(SCRIPT[s].data, SCRIPT[s].last, SCRIPT[s].check, SCRIPT[s].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin plen_raw = 8;  rlen_raw = 8;  end
        1: begin plen_raw = 1;  rlen_raw = 0;  end
        2: begin plen_raw = 0;  rlen_raw = $urandom_range(8, 0); end
        3: begin plen_raw = 15; rlen_raw = 15; end
        default: begin
          plen_raw = $urandom_range(8, 1);
          rlen_raw = $urandom_range(8, 0);
        end
      endcase
      // A small alphabet per phase makes near misses and overlaps common.
      foreach (alphabet[j]) alphabet[j] = 8'($urandom_range(255, 0));
      for (int j = 0; j < 8; j++) pattern[8*j +: 8] = alphabet[$urandom_range(3, 0)];
      upper = (ph >= 4 && $urandom_range(1, 0) == 1) ? ({$urandom, $urandom} & ~64'hF) : '0;
      write_reg(CFG_PAT_LEN, upper | 64'(plen_raw));
      write_reg(CFG_PAT_DATA, pattern);
      write_reg(CFG_REP_LEN, upper | 64'(rlen_raw));
      write_reg(CFG_REP_DATA, {$urandom, $urandom});
      no_idle = (ph == 5);
      eff = (plen_raw == 0) ? 1 : ((plen_raw > WORD_MAX) ? WORD_MAX : plen_raw);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        burst.delete();
        if (pick < 35) begin
          for (int j = 0; j < eff; j++) burst.push_back(pattern[8*j +: 8]);
        end else if (pick < 50 && eff > 1) begin
          cut = $urandom_range(eff - 1, 1);
          for (int j = 0; j < cut; j++) burst.push_back(pattern[8*j +: 8]);
        end else if (pick < 85) begin
          burst.push_back(alphabet[$urandom_range(3, 0)]);
        end else begin
          burst.push_back(8'($urandom_range(255, 0)));
        end
        foreach (burst[k]) begin
          // Most phases close their stream; two leave bytes held across the
          // register change.
          last = ($urandom_range(99, 0) < 5) || (sent == PHASE_ITEMS - 1 && ph % 4 != 2);
          send_byte(burst[k], last, BY_MODEL, '0);
          sent++;
        end
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
